// ===== design/psev_pkg.sv =====
// Shared types, constants and helpers for the polynomial series evaluator.
package psev_pkg;

  localparam int MAX_TERMS = 16;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int CIDX_W    = 4;
  localparam int DEG_W     = 4;
  localparam int STATUS_W  = 2;
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;
  localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int NPROD_W   = 2 * DATA_W + 1;
  localparam int ACC_W     = 2 * DATA_W - FRAC_BITS + IDX_W + 1;
  localparam int WIDE_W    = 2 * DATA_W + 2;

  localparam logic signed [DATA_W-1:0] Q_ONE = DATA_W'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [REG_IDX_W-1:0] {
    REG_READY_FLAG   = 3'd0,
    REG_BASIS_SELECT = 3'd1,
    REG_POLY_DEGREE  = 3'd2,
    REG_X_CENTER     = 3'd3,
    REG_X_INV_SCALE  = 3'd4
  } reg_idx_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_READY = 2'd1,
    STATUS_SATURATED = 2'd2
  } status_e;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_EVAL = 1'b1
  } req_type_e;

  typedef enum logic {
    BASIS_MONOMIAL  = 1'b0,
    BASIS_CHEBYSHEV = 1'b1
  } basis_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_NORM,
    S_MUL,
    S_ACC,
    S_WRAP
  } state_e;

  typedef struct packed {
    logic                     load_en;
    logic [CIDX_W-1:0]        load_idx;
    logic signed [DATA_W-1:0] load_data;
    logic                     shift_en;
  } chain_ctrl_t;

  typedef struct packed {
    logic                     sat;
    logic signed [DATA_W-1:0] value;
  } clamp_t;

  function automatic clamp_t sat_clamp(input logic signed [WIDE_W-1:0] v);
    clamp_t r;
    if (v > WIDE_W'(Q_MAX)) begin
      r.sat   = 1'b1;
      r.value = Q_MAX;
    end else if (v < WIDE_W'(Q_MIN)) begin
      r.sat   = 1'b1;
      r.value = Q_MIN;
    end else begin
      r.sat   = 1'b0;
      r.value = DATA_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== design/psev_if.sv =====
// Request and response channel interfaces of the polynomial series evaluator.
interface psev_req_if
  import psev_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [CIDX_W-1:0]        coeff_index;
  logic signed [DATA_W-1:0] coeff_value;
  logic signed [DATA_W-1:0] x_value;

  modport source (output valid, req_type, coeff_index, coeff_value, x_value, input ready);
  modport sink   (input valid, req_type, coeff_index, coeff_value, x_value, output ready);
endinterface

interface psev_rsp_if
  import psev_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] q_value;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, q_value, status, input ready);
  modport sink   (input valid, q_value, status, output ready);
endinterface

// ===== design/poly_series_evaluator.sv =====
// Load beat: writes its coefficient cell. Evaluate beat of degree n: a shared multiply step
// and an accumulate step for each of the n+1 terms, preceded by Chebyshev normalization
// (scale, normalize) in that basis, then the coefficient ring is rotated back into alignment
// and the result enters the output register; a not-ready evaluation skips the terms. Beats
// are taken only while idle; a result that cannot enter a full output register holds the evaluator until it can.
// Reset (rst_ni low, asynchronous) resets configuration and clears all coefficients at once.
module poly_series_evaluator
  import psev_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [ADDR_W-1:0] paddr_i,
  input  logic [DATA_W-1:0] pwdata_i,
  output logic [DATA_W-1:0] prdata_o,
  output logic              pready_o,
  psev_req_if.sink          req_i,
  psev_rsp_if.source        rsp_o
);

  logic                     ready_flag_q;
  logic                     basis_select_q;
  logic [DEG_W-1:0]         poly_degree_q;
  logic signed [DATA_W-1:0] x_center_q;
  logic signed [DATA_W-1:0] x_inv_scale_q;
  logic [REG_IDX_W-1:0]     reg_idx;
  logic                     cfg_write;

  state_e                   state_q, state_d;
  logic [IDX_W-1:0]         rot_q, rot_d;
  logic [IDX_W-1:0]         k_q, k_d;
  logic [IDX_W-1:0]         n_q, n_d;
  logic                     sat_q, sat_d;
  logic signed [DATA_W:0]   d_q, d_d;
  logic signed [NPROD_W-1:0] pn_q, pn_d;
  logic signed [DATA_W-1:0] mul_op_q, mul_op_d;
  logic signed [DATA_W-1:0] b_q, b_d;
  logic signed [DATA_W-1:0] b_prev_q, b_prev_d;
  logic signed [PROD_W-1:0] pb_q, pb_d;
  logic signed [PROD_W-1:0] pt_q, pt_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [DATA_W-1:0] res_val_q, res_val_d;
  status_e                  res_status_q, res_status_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] out_val_q, out_val_d;
  status_e                  out_status_q, out_status_d;

  chain_ctrl_t              chain_ctrl;
  logic signed [DATA_W-1:0] head;

  assign reg_idx   = paddr_i[ADDR_W-1:2];
  assign cfg_write = psel_i && penable_i && pwrite_i;
  assign pready_o  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_flag_q   <= 1'b0;
      basis_select_q <= 1'b0;
      poly_degree_q  <= '0;
      x_center_q     <= '0;
      x_inv_scale_q  <= Q_ONE;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_READY_FLAG:   ready_flag_q   <= pwdata_i[0];
        REG_BASIS_SELECT: basis_select_q <= pwdata_i[0];
        REG_POLY_DEGREE:  poly_degree_q  <= pwdata_i[DEG_W-1:0];
        REG_X_CENTER:     x_center_q     <= pwdata_i;
        REG_X_INV_SCALE:  x_inv_scale_q  <= pwdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_READY_FLAG:   prdata_o = {{(DATA_W-1){1'b0}}, ready_flag_q};
      REG_BASIS_SELECT: prdata_o = {{(DATA_W-1){1'b0}}, basis_select_q};
      REG_POLY_DEGREE:  prdata_o = {{(DATA_W-DEG_W){1'b0}}, poly_degree_q};
      REG_X_CENTER:     prdata_o = x_center_q;
      REG_X_INV_SCALE:  prdata_o = x_inv_scale_q;
      default:          prdata_o = '0;
    endcase
  end

  psev_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (chain_ctrl),
    .head_o (head)
  );

  always_comb begin
    logic signed [NPROD_W-1:0] pn_sh;
    logic signed [PROD_W-1:0]  pb_sh;
    logic signed [PROD_W-1:0]  pb_sh2;
    logic signed [PROD_W-1:0]  pt_sh;
    logic signed [ACC_W-1:0]   acc_sum;
    clamp_t                    cl;
    clamp_t                    cl_acc;

    pn_sh   = pn_q >>> FRAC_BITS;
    pb_sh   = pb_q >>> FRAC_BITS;
    pb_sh2  = pb_q >>> (FRAC_BITS - 1);
    pt_sh   = pt_q >>> FRAC_BITS;
    acc_sum = acc_q + ACC_W'(pt_sh);
    cl      = '0;
    cl_acc  = sat_clamp(WIDE_W'(acc_sum));

    state_d      = state_q;
    rot_d        = rot_q;
    k_d          = k_q;
    n_d          = n_q;
    sat_d        = sat_q;
    d_d          = d_q;
    pn_d         = pn_q;
    mul_op_d     = mul_op_q;
    b_d          = b_q;
    b_prev_d     = b_prev_q;
    pb_d         = pb_q;
    pt_d         = pt_q;
    acc_d        = acc_q;
    res_val_d    = res_val_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_val_d    = out_val_q;
    out_status_d = out_status_q;

    chain_ctrl.load_en   = 1'b0;
    chain_ctrl.load_idx  = req_i.coeff_index;
    chain_ctrl.load_data = req_i.coeff_value;
    chain_ctrl.shift_en  = 1'b0;

    req_i.ready = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          if (req_type_e'(req_i.req_type) == REQ_LOAD) begin
            chain_ctrl.load_en = 1'b1;
          end else begin
            k_d      = '0;
            acc_d    = '0;
            sat_d    = 1'b0;
            b_d      = Q_ONE;
            b_prev_d = Q_ONE;
            if (32'(poly_degree_q) > MAX_TERMS - 1) begin
              n_d = IDX_W'(MAX_TERMS - 1);
            end else begin
              n_d = IDX_W'(poly_degree_q);
            end
            if (!ready_flag_q) begin
              res_val_d    = '0;
              res_status_d = STATUS_NOT_READY;
              state_d      = S_WRAP;
            end else if (basis_e'(basis_select_q) == BASIS_MONOMIAL) begin
              mul_op_d = req_i.x_value;
              state_d  = S_MUL;
            end else begin
              d_d     = (DATA_W+1)'(req_i.x_value) - (DATA_W+1)'(x_center_q);
              state_d = S_SCALE;
            end
          end
        end
      end
      S_SCALE: begin
        pn_d    = NPROD_W'(d_q) * NPROD_W'(x_inv_scale_q);
        state_d = S_NORM;
      end
      S_NORM: begin
        cl       = sat_clamp(WIDE_W'(pn_sh));
        mul_op_d = cl.value;
        sat_d    = sat_q | cl.sat;
        state_d  = S_MUL;
      end
      S_MUL: begin
        pb_d    = PROD_W'(b_q) * PROD_W'(mul_op_q);
        pt_d    = PROD_W'(head) * PROD_W'(b_q);
        state_d = S_ACC;
      end
      S_ACC: begin
        acc_d = acc_sum;
        if (k_q < n_q) begin
          if (basis_e'(basis_select_q) == BASIS_MONOMIAL) begin
            cl = sat_clamp(WIDE_W'(pb_sh));
          end else if (k_q == '0) begin
            cl.sat   = 1'b0;
            cl.value = mul_op_q;
          end else begin
            cl = sat_clamp(WIDE_W'(pb_sh2) - WIDE_W'(b_prev_q));
          end
          b_prev_d            = b_q;
          b_d                 = cl.value;
          sat_d               = sat_q | cl.sat;
          k_d                 = k_q + 1'b1;
          chain_ctrl.shift_en = 1'b1;
          rot_d               = (32'(rot_q) == MAX_TERMS - 1) ? '0 : rot_q + 1'b1;
          state_d             = S_MUL;
        end else begin
          res_val_d    = cl_acc.value;
          res_status_d = (sat_q | cl_acc.sat) ? STATUS_SATURATED : STATUS_OK;
          state_d      = S_WRAP;
        end
      end
      S_WRAP: begin
        if (rot_q != '0) begin
          chain_ctrl.shift_en = 1'b1;
          rot_d               = (32'(rot_q) == MAX_TERMS - 1) ? '0 : rot_q + 1'b1;
        end else if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_val_d    = res_val_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rot_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rot_q       <= rot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q          <= k_d;
    n_q          <= n_d;
    sat_q        <= sat_d;
    d_q          <= d_d;
    pn_q         <= pn_d;
    mul_op_q     <= mul_op_d;
    b_q          <= b_d;
    b_prev_q     <= b_prev_d;
    pb_q         <= pb_d;
    pt_q         <= pt_d;
    acc_q        <= acc_d;
    res_val_q    <= res_val_d;
    res_status_q <= res_status_d;
    out_val_q    <= out_val_d;
    out_status_q <= out_status_d;
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.q_value = out_val_q;
  assign rsp_o.status  = out_status_q;

`ifndef ASSERT_OFF
  a_ring_aligned_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> rot_q == '0)
    else $error("coefficient ring not realigned when idle");

  a_term_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MUL |-> k_q <= n_q)
    else $error("term index beyond degree");

  a_eval_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready && req_i.req_type == REQ_EVAL |=> state_q != S_IDLE)
    else $error("evaluate beat did not start work");

  a_not_ready_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status == STATUS_NOT_READY |-> rsp_o.q_value == '0)
    else $error("not-ready result carries a nonzero value");
`endif

endmodule

// ===== design/psev_cell.sv =====
// One coefficient cell of the rotating coefficient ring.
module psev_cell
  import psev_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_en_i,
  input  logic signed [DATA_W-1:0] load_data_i,
  input  logic                     shift_en_i,
  input  logic signed [DATA_W-1:0] shift_data_i,
  output logic signed [DATA_W-1:0] coeff_o
);

  logic signed [DATA_W-1:0] coeff_q;
  logic signed [DATA_W-1:0] coeff_d;

  always_comb begin
    coeff_d = coeff_q;
    if (load_en_i) begin
      coeff_d = load_data_i;
    end else if (shift_en_i) begin
      coeff_d = shift_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= '0;
    end else begin
      coeff_q <= coeff_d;
    end
  end

  assign coeff_o = coeff_q;

endmodule

// ===== design/psev_chain.sv =====
// Ring of coefficient cells; cell zero presents the current term's coefficient.
module psev_chain
  import psev_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  chain_ctrl_t              ctrl_i,
  output logic signed [DATA_W-1:0] head_o
);

  logic signed [DATA_W-1:0] coeff [MAX_TERMS];

  for (genvar i = 0; i < MAX_TERMS; i++) begin : g_cell
    localparam int NEXT = (i == MAX_TERMS - 1) ? 0 : i + 1;
    logic load_hit;

    assign load_hit = ctrl_i.load_en && (32'(ctrl_i.load_idx) == i);

    psev_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .load_en_i    (load_hit),
      .load_data_i  (ctrl_i.load_data),
      .shift_en_i   (ctrl_i.shift_en),
      .shift_data_i (coeff[NEXT]),
      .coeff_o      (coeff[i])
    );
  end

  assign head_o = coeff[0];

endmodule
